/* sv/pit_pkg.sv */
// Shared types and codes for the page index table.
// Holds request mode codes, status codes and the stored entry layout.
// No dependencies.
package pit_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int OBJ_W       = 8;
	localparam int PAGE_W      = 16;
	localparam int PAY_W       = 32;
	localparam int MODE_W      = 3;
	localparam int STAT_W      = 3;
	localparam int CNT_OUT_W   = 7;

	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FIND   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_EXISTS    = 3'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
	localparam logic [STAT_W-1:0] STAT_UNMATCHED = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;

	typedef struct packed {
		logic [OBJ_W-1:0]  obj;
		logic [PAGE_W-1:0] page;
		logic [PAY_W-1:0]  payload;
	} entry_t;

endpackage

/* sv/page_index_table.sv */
// Page index table: keyed entry store with insert, update, delete, find and clear.
// Clear and unused modes skip the scan; the others scan one live entry per cycle,
// and a delete that hits then reads the last entry and writes it into the freed slot.
// Throughput: one request at a time; in_ready is high only while idle.
// Reset clears the fill count and handshake state; stored entries are not cleared.
// Depends on pit_pkg and pit_mem.
module page_index_table #(
	parameter int ENTRIES = pit_pkg::ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pit_pkg::MODE_W-1:0]        mode,
	input  logic                              replace_if_present,
	input  logic [pit_pkg::OBJ_W-1:0]         object_key,
	input  logic [pit_pkg::PAGE_W-1:0]        page_key,
	input  logic [pit_pkg::OBJ_W-1:0]         new_object_key,
	input  logic [pit_pkg::PAGE_W-1:0]        new_page_key,
	input  logic [pit_pkg::PAY_W-1:0]         entry_payload,
	input  logic [pit_pkg::OBJ_W-1:0]         object_count,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pit_pkg::STAT_W-1:0]        status,
	output logic [pit_pkg::PAY_W-1:0]         found_payload,
	output logic [pit_pkg::CNT_OUT_W-1:0]     entry_count
);
	import pit_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_ACT    = 6'b000100,
		S_DEL_RD = 6'b001000,
		S_DEL_WR = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] addr_q;
	logic          hit_q;
	logic          rd_vld_s1;
	logic [IW-1:0] idx_s1;
	logic          out_valid_q;

	logic [MODE_W-1:0] mode_q;
	logic              replace_q;
	logic [OBJ_W-1:0]  obj_q;
	logic [PAGE_W-1:0] page_q;
	logic [OBJ_W-1:0]  new_obj_q;
	logic [PAGE_W-1:0] new_page_q;
	logic [PAY_W-1:0]  payload_q;
	logic [OBJ_W-1:0]  objects_q;
	logic [IW-1:0]     slot_q;
	logic [PAY_W-1:0]  found_q;
	logic [STAT_W-1:0] res_status_q;
	logic [STAT_W-1:0] out_status_q;
	logic [PAY_W-1:0]  out_found_q;
	logic [CNT_OUT_W-1:0] out_count_q;

	logic          accept;
	logic          hit;
	logic          issue;
	logic          full;
	logic          load;
	logic          we;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;
	logic [IW-1:0] rd_addr;
	entry_t        rd_data;
	logic [CW+CNT_OUT_W-1:0] count_ext;

	pit_mem #(.ENTRIES(ENTRIES)) u_mem (
		.clk     (clk),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign hit       = rd_vld_s1 && (rd_data.obj == obj_q) && (rd_data.page == page_q);
	assign issue     = (state_q == S_SCAN) && (addr_q < fill_q) && !hit;
	assign full      = (fill_q == CW'(ENTRIES));
	assign load      = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign rd_addr   = (state_q == S_DEL_RD) ? IW'(fill_q - CW'(1)) : addr_q[IW-1:0];
	assign count_ext = {{CNT_OUT_W{1'b0}}, fill_q};

	always_comb begin
		we      = 1'b0;
		wr_addr = slot_q;
		wr_data = '{obj: obj_q, page: page_q, payload: payload_q};
		case (state_q)
			S_ACT: begin
				case (mode_q)
					MODE_INSERT: begin
						if (hit_q) begin
							we = replace_q;
						end else if (!full) begin
							we      = 1'b1;
							wr_addr = fill_q[IW-1:0];
						end
					end
					MODE_UPDATE: begin
						we      = hit_q;
						wr_data = '{obj: new_obj_q, page: new_page_q, payload: payload_q};
					end
					default: begin
						we = 1'b0;
					end
				endcase
			end
			S_DEL_WR: begin
				we      = 1'b1;
				wr_data = rd_data;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			addr_q      <= '0;
			hit_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q <= '0;
						hit_q  <= 1'b0;
						case (mode)
							MODE_CLEAR: begin
								fill_q  <= '0;
								state_q <= S_DONE;
							end
							MODE_INSERT, MODE_UPDATE, MODE_DELETE, MODE_FIND: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						addr_q <= addr_q + CW'(1);
					end
					if (hit) begin
						hit_q   <= 1'b1;
						state_q <= S_ACT;
					end else if (addr_q >= fill_q) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					case (mode_q)
						MODE_INSERT: begin
							state_q <= S_DONE;
							if (!hit_q && !full) begin
								fill_q <= fill_q + CW'(1);
							end
						end
						MODE_DELETE: begin
							if (hit_q) begin
								state_q <= S_DEL_RD;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_DEL_RD: begin
					state_q <= S_DEL_WR;
				end
				S_DEL_WR: begin
					fill_q  <= fill_q - CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result data
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q[IW-1:0];
		if (load) begin
			out_status_q <= res_status_q;
			out_found_q  <= found_q;
			out_count_q  <= count_ext[CNT_OUT_W-1:0];
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q       <= mode;
					replace_q    <= replace_if_present;
					obj_q        <= object_key;
					page_q       <= page_key;
					new_obj_q    <= new_object_key;
					new_page_q   <= new_page_key;
					payload_q    <= entry_payload;
					objects_q    <= object_count;
					found_q      <= '0;
					res_status_q <= (mode == MODE_CLEAR && object_count <= OBJ_W'(1))
						? STAT_UNMATCHED : STAT_OK;
				end
			end
			S_SCAN: begin
				if (hit) begin
					slot_q <= idx_s1;
					if (mode_q == MODE_FIND) begin
						found_q <= rd_data.payload;
					end
				end
			end
			S_ACT: begin
				case (mode_q)
					MODE_INSERT: begin
						if (hit_q && !replace_q) begin
							res_status_q <= STAT_EXISTS;
						end else if (!hit_q && full) begin
							res_status_q <= STAT_FULL;
						end
					end
					MODE_UPDATE, MODE_DELETE, MODE_FIND: begin
						if (!hit_q) begin
							res_status_q <= STAT_NOT_FOUND;
						end
					end
					default: begin
						res_status_q <= res_status_q;
					end
				endcase
			end
			S_DEL_WR: begin
				if (objects_q > OBJ_W'(1) || fill_q > CW'(2)) begin
					res_status_q <= STAT_OK;
				end else begin
					res_status_q <= STAT_UNMATCHED;
				end
			end
			default: begin
				res_status_q <= res_status_q;
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign found_payload = out_found_q;
	assign entry_count   = out_count_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(ENTRIES))
		else $error("fill count above table depth");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_ACT || state_q == S_DEL_WR))
		else $error("table write outside action states");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == MODE_CLEAR |=> fill_q == '0)
		else $error("clear left entries");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CW'(idx_s1) < fill_q))
		else $error("scan read beyond live entries");

	a_delete_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEL_RD |-> fill_q != '0)
		else $error("delete on empty table");
`endif

endmodule

/* sv/pit_mem.sv */
// Entry storage for the page index table: one write port, one registered read port.
// Depends on pit_pkg for the entry layout.
module pit_mem #(
	parameter int ENTRIES = pit_pkg::ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(ENTRIES)-1:0]   wr_addr,
	input  pit_pkg::entry_t              wr_data,
	input  logic [$clog2(ENTRIES)-1:0]   rd_addr,
	output pit_pkg::entry_t              rd_data
);
	import pit_pkg::*;

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* bench/page_index_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for page_index_table: directed table, then random request rounds.
// Predicts untyped results from a shadow table copy. Depends on pit_pkg and the RTL.
module page_index_table_tb;
	import pit_pkg::*;

	localparam int TABLE_DEPTH   = ENTRIES_DEF;
	localparam int KEY_POOL      = 96;
	localparam int RANDOM_ITEMS  = 1050;
	localparam int LONG_HOLD_AT  = 500;
	localparam int LONG_HOLD     = 600;
	localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;

	localparam int ROUND_FILL  = 0;
	localparam int ROUND_MIXED = 1;
	localparam int ROUND_DRAIN = 2;
	localparam int ROUND_KINDS = 3;

	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              overwrite;
		logic [OBJ_W-1:0]  obj;
		logic [PAGE_W-1:0] page;
		logic [OBJ_W-1:0]  new_obj;
		logic [PAGE_W-1:0] repl_page;
		logic [PAY_W-1:0]  payload;
		logic [OBJ_W-1:0]  objects;
	} request_t;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [PAY_W-1:0]     payload;
		logic [CNT_OUT_W-1:0] count;
	} outcome_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		outcome_t want;
	} directed_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [MODE_W-1:0]    mode;
	logic                 replace_if_present;
	logic [OBJ_W-1:0]     object_key;
	logic [PAGE_W-1:0]    page_key;
	logic [OBJ_W-1:0]     new_object_key;
	logic [PAGE_W-1:0]    new_page_key;
	logic [PAY_W-1:0]     entry_payload;
	logic [OBJ_W-1:0]     object_count;
	logic                 out_valid;
	logic                 out_ready;
	logic [STAT_W-1:0]    status;
	logic [PAY_W-1:0]     found_payload;
	logic [CNT_OUT_W-1:0] entry_count;

	logic [OBJ_W+PAGE_W-1:0] table_keys [TABLE_DEPTH];
	logic [PAY_W-1:0]        table_payloads [TABLE_DEPTH];
	int                      table_fill;
	int                      peak_fill;

	logic [OBJ_W+PAGE_W-1:0] key_pool [KEY_POOL];
	outcome_t                pending_outcomes [$];
	directed_row_t           directed_rows [$];

	int error_count;
	int requests_sent;
	int results_taken;
	int status_tally [5];

	page_index_table #(.ENTRIES(TABLE_DEPTH)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("page_index_table_tb: done, errors");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	function automatic outcome_t apply_request(input request_t r);
		outcome_t                o;
		int                      hit;
		logic [OBJ_W+PAGE_W-1:0] k;
		k = {r.obj, r.page};
		hit = -1;
		for (int i = 0; i < table_fill; i++)
			if (hit < 0 && table_keys[i] == k)
				hit = i;
		o.status = STAT_OK;
		o.payload = '0;
		case (r.mode)
			MODE_INSERT: begin
				if (hit >= 0) begin
					if (r.overwrite)
						table_payloads[hit] = r.payload;
					else
						o.status = STAT_EXISTS;
				end else if (table_fill >= TABLE_DEPTH) begin
					o.status = STAT_FULL;
				end else begin
					table_keys[table_fill] = k;
					table_payloads[table_fill] = r.payload;
					table_fill++;
				end
			end
			MODE_UPDATE: begin
				if (hit >= 0) begin
					table_keys[hit] = {r.new_obj, r.repl_page};
					table_payloads[hit] = r.payload;
				end else begin
					o.status = STAT_NOT_FOUND;
				end
			end
			MODE_DELETE: begin
				if (hit < 0) begin
					o.status = STAT_NOT_FOUND;
				end else begin
					table_keys[hit] = table_keys[table_fill-1];
					table_payloads[hit] = table_payloads[table_fill-1];
					table_fill--;
					o.status = (r.objects > 1 || table_fill > 1) ? STAT_OK : STAT_UNMATCHED;
				end
			end
			MODE_FIND: begin
				if (hit >= 0)
					o.payload = table_payloads[hit];
				else
					o.status = STAT_NOT_FOUND;
			end
			MODE_CLEAR: begin
				table_fill = 0;
				o.status = (r.objects > 1) ? STAT_OK : STAT_UNMATCHED;
			end
			default: ;
		endcase
		if (table_fill > peak_fill)
			peak_fill = table_fill;
		o.count = CNT_OUT_W'(table_fill);
		return o;
	endfunction

	function automatic void add_row(input logic [MODE_W-1:0] m, input logic ow,
			input logic [OBJ_W-1:0] ob, input logic [PAGE_W-1:0] pg,
			input logic [OBJ_W-1:0] nob, input logic [PAGE_W-1:0] npg,
			input logic [PAY_W-1:0] pay, input logic [OBJ_W-1:0] objs,
			input logic typed, input logic [STAT_W-1:0] st,
			input logic [PAY_W-1:0] fp, input logic [CNT_OUT_W-1:0] cnt);
		directed_row_t row;
		row.req = '{m, ow, ob, pg, nob, npg, pay, objs};
		row.typed = typed;
		row.want = '{st, fp, cnt};
		directed_rows.push_back(row);
	endfunction

	function automatic logic [OBJ_W+PAGE_W-1:0] pick_key();
		if ($urandom_range(0, 9) != 0)
			return key_pool[$urandom_range(0, KEY_POOL-1)];
		return (OBJ_W+PAGE_W)'($urandom());
	endfunction

	function automatic request_t random_request(input int kind, input int cursor);
		request_t                r;
		int                      roll;
		logic [OBJ_W+PAGE_W-1:0] k;
		logic [OBJ_W+PAGE_W-1:0] nk;
		roll = $urandom_range(0, 99);
		k = pick_key();
		nk = ($urandom_range(0, 1) != 0) ? pick_key() : (OBJ_W+PAGE_W)'($urandom());
		r.overwrite = 1'($urandom_range(0, 1));
		r.payload = $urandom();
		r.objects = ($urandom_range(0, 1) != 0) ? OBJ_W'($urandom_range(0, 2))
			: OBJ_W'($urandom_range(0, 255));
		case (kind)
			ROUND_FILL: begin
				if (roll < 85) begin
					r.mode = MODE_INSERT;
					k = key_pool[cursor % KEY_POOL];
				end else if (roll < 93) begin
					r.mode = MODE_FIND;
				end else if (roll < 97) begin
					r.mode = MODE_UPDATE;
				end else begin
					r.mode = MODE_DELETE;
				end
			end
			ROUND_DRAIN: begin
				if (roll < 85) begin
					r.mode = MODE_DELETE;
					k = key_pool[cursor % KEY_POOL];
				end else if (roll < 95) begin
					r.mode = MODE_FIND;
				end else begin
					r.mode = MODE_INSERT;
				end
			end
			default: begin
				if (roll < 35)
					r.mode = MODE_INSERT;
				else if (roll < 50)
					r.mode = MODE_UPDATE;
				else if (roll < 65)
					r.mode = MODE_DELETE;
				else if (roll < 90)
					r.mode = MODE_FIND;
				else if (roll < 92)
					r.mode = MODE_CLEAR;
				else if (roll < 96)
					r.mode = MODE_W'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
				else
					r.mode = MODE_FIND;
			end
		endcase
		{r.obj, r.page} = k;
		{r.new_obj, r.repl_page} = nk;
		return r;
	endfunction

	task automatic push_request(input request_t r, input logic typed, input outcome_t fixed);
		int       gap;
		outcome_t want;
		gap = ((requests_sent / 120) % 4 == 3) ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode = r.mode;
		replace_if_present = r.overwrite;
		object_key = r.obj;
		page_key = r.page;
		new_object_key = r.new_obj;
		new_page_key = r.repl_page;
		entry_payload = r.payload;
		object_count = r.objects;
		in_valid = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		want = apply_request(r);
		pending_outcomes.push_back(typed ? fixed : want);
		requests_sent++;
		@(negedge clk);
	endtask

	initial begin : request_side
		logic [OBJ_W+PAGE_W-1:0] cand;
		logic                    dup;
		int                      issued;
		int                      round_no;
		int                      kind;
		int                      round_len;
		int                      start;
		outcome_t                none;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_INSERT;
		replace_if_present = 1'b0;
		object_key = '0;
		page_key = '0;
		new_object_key = '0;
		new_page_key = '0;
		entry_payload = '0;
		object_count = '0;
		error_count = 0;
		requests_sent = 0;
		table_fill = 0;
		peak_fill = 0;
		none = '0;
		foreach (status_tally[i])
			status_tally[i] = 0;
		for (int i = 0; i < KEY_POOL; i++) begin
			do begin
				cand = (OBJ_W+PAGE_W)'($urandom());
				dup = 1'b0;
				for (int j = 0; j < i; j++)
					if (key_pool[j] == cand)
						dup = 1'b1;
			end while (dup);
			key_pool[i] = cand;
		end

		add_row(MODE_FIND,   0, 8'h00, 16'h0000, 0, 0, 0, 0, 1, STAT_NOT_FOUND, 0, 0);
		add_row(MODE_DELETE, 0, 8'hFF, 16'hFFFF, 0, 0, 0, 8'hFF, 1, STAT_NOT_FOUND, 0, 0);
		add_row(MODE_UPDATE, 0, 8'h00, 16'h0000, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 0,
			1, STAT_NOT_FOUND, 0, 0);
		add_row(MODE_CLEAR,  0, 0, 0, 0, 0, 0, 8'h00, 1, STAT_UNMATCHED, 0, 0);
		add_row(MODE_CLEAR,  1, 0, 0, 0, 0, 0, 8'hFF, 1, STAT_OK, 0, 0);
		add_row(MODE_CLEAR,  0, 0, 0, 0, 0, 0, 8'h01, 1, STAT_UNMATCHED, 0, 0);
		add_row(MODE_INSERT, 0, 8'hFF, 16'hFFFF, 0, 0, 32'hFFFF_FFFF, 0, 1, STAT_OK, 0, 1);
		add_row(MODE_INSERT, 1, 8'h00, 16'h0000, 0, 0, 32'h0, 0, 1, STAT_OK, 0, 2);
		add_row(MODE_INSERT, 0, 8'hFF, 16'hFFFF, 0, 0, 32'h0, 0, 1, STAT_EXISTS, 0, 2);
		add_row(MODE_FIND,   0, 8'hFF, 16'hFFFF, 0, 0, 0, 0, 1, STAT_OK, 32'hFFFF_FFFF, 2);
		add_row(MODE_INSERT, 1, 8'hFF, 16'hFFFF, 0, 0, 32'h5A5A_A5A5, 0, 0, 0, 0, 0);
		add_row(MODE_FIND,   0, 8'hFF, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(MODE_UPDATE, 0, 8'h00, 16'h0000, 8'h12, 16'h3456, 32'hDEAD_BEEF, 0,
			0, 0, 0, 0);
		add_row(MODE_UPDATE, 0, 8'hFF, 16'hFFFF, 8'h12, 16'h3456, 32'h0123_4567, 0,
			0, 0, 0, 0);
		add_row(MODE_FIND,   0, 8'h12, 16'h3456, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(MODE_SPARE_A, 0, 8'h12, 16'h3456, 0, 0, 0, 0, 1, STAT_OK, 0, 2);
		add_row(MODE_SPARE_B, 1, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF,
			1, STAT_OK, 0, 2);
		add_row(MODE_SPARE_C, 0, 8'h00, 16'h0000, 0, 0, 0, 0, 1, STAT_OK, 0, 2);
		add_row(MODE_DELETE, 0, 8'h12, 16'h3456, 0, 0, 0, 8'h01, 1, STAT_UNMATCHED, 0, 1);
		add_row(MODE_FIND,   0, 8'h12, 16'h3456, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(MODE_INSERT, 0, 8'h80, 16'h8000, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0);
		add_row(MODE_DELETE, 0, 8'h80, 16'h8000, 0, 0, 0, 8'h02, 1, STAT_OK, 0, 1);
		add_row(MODE_DELETE, 0, 8'h12, 16'h3456, 0, 0, 0, 8'h00, 1, STAT_UNMATCHED, 0, 0);
		add_row(MODE_FIND,   0, 8'h12, 16'h3456, 0, 0, 0, 0, 1, STAT_NOT_FOUND, 0, 0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			push_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

		issued = 0;
		round_no = 0;
		while (issued < RANDOM_ITEMS) begin
			kind = round_no % ROUND_KINDS;
			round_len = (kind == ROUND_MIXED) ? 100 : 110;
			start = $urandom_range(0, KEY_POOL-1);
			// hold until the block has answered everything before each drain round
			if (kind == ROUND_DRAIN && pending_outcomes.size() != 0) begin
				in_valid = 1'b0;
				while (pending_outcomes.size() != 0)
					@(negedge clk);
			end
			for (int n = 0; n < round_len && issued < RANDOM_ITEMS; n++) begin
				push_request(random_request(kind, start + n), 1'b0, none);
				issued++;
			end
			round_no++;
		end
		in_valid = 1'b0;

		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("page_index_table_tb: %0d requests, %0d results, peak fill %0d of %0d",
			requests_sent, results_taken, peak_fill, TABLE_DEPTH);
		$display("page_index_table_tb: ok %0d, exists %0d, not found %0d, unmatched %0d, full %0d",
			status_tally[STAT_OK], status_tally[STAT_EXISTS], status_tally[STAT_NOT_FOUND],
			status_tally[STAT_UNMATCHED], status_tally[STAT_FULL]);
		if (error_count == 0)
			$display("page_index_table_tb: done, clean");
		else
			$display("page_index_table_tb: done, errors");
		$finish;
	end

	task automatic check_result();
		outcome_t want;
		if (status < 5)
			status_tally[status]++;
		if (pending_outcomes.size() == 0) begin
			flag_mismatch($sformatf("result with nothing pending, status %0d", status));
			return;
		end
		want = pending_outcomes.pop_front();
		if (status !== want.status)
			flag_mismatch($sformatf("result %0d status %0d, want %0d",
				results_taken, status, want.status));
		if (found_payload !== want.payload)
			flag_mismatch($sformatf("result %0d found_payload %h, want %h",
				results_taken, found_payload, want.payload));
		if (entry_count !== want.count)
			flag_mismatch($sformatf("result %0d entry_count %0d, want %0d",
				results_taken, entry_count, want.count));
		results_taken++;
	endtask

	initial begin : result_side
		int stall;
		results_taken = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (results_taken == LONG_HOLD_AT)
				stall = LONG_HOLD;
			else
				stall = ((results_taken / 90) % 4 == 1) ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			check_result();
			@(negedge clk);
		end
	end

endmodule

/* sim.f */
sv/pit_pkg.sv
sv/pit_mem.sv
sv/page_index_table.sv
bench/page_index_table_tb.sv
